FILE: rtl/core/touch_report_decoder_scaler_macros.svh
// Assertion macros shared by the touch report decoder files.
`ifndef TOUCH_REPORT_DECODER_SCALER_MACROS_SVH
`define TOUCH_REPORT_DECODER_SCALER_MACROS_SVH

`ifndef SYNTHESIS
`define TRDS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define TRDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define TRDS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TRDS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/trds_pkg.sv
package trds_pkg;

    localparam int PIXEL_BITS  = 12;
    localparam int HIGH_SHIFT  = 7;
    localparam int GAIN_FRAC   = 16;
    localparam int BYTE_W      = 8;
    localparam int RAW_W       = 16;
    localparam int GAIN_W      = 24;
    localparam int LIMIT_W     = 12;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int PROD_W      = RAW_W + GAIN_W;
    localparam int SCALED_W    = PROD_W - GAIN_FRAC;

    localparam logic [LIMIT_W-1:0] PIX_MAX = (PIXEL_BITS >= LIMIT_W) ? {LIMIT_W{1'b1}}
                                             : LIMIT_W'((1 << PIXEL_BITS) - 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PRESS_CODE = 3'd0,
        REG_COORD_MIN  = 3'd1,
        REG_X_GAIN     = 3'd2,
        REG_Y_GAIN     = 3'd3,
        REG_X_LIMIT    = 3'd4,
        REG_Y_LIMIT    = 3'd5
    } trds_reg_t;

    typedef enum logic [2:0] {
        POS_HUNT   = 3'd0,
        POS_X_LOW  = 3'd1,
        POS_X_HIGH = 3'd2,
        POS_Y_LOW  = 3'd3,
        POS_Y_HIGH = 3'd4
    } trds_pos_t;

    typedef struct packed {
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
    } trds_raw_t;

    typedef struct packed {
        logic [RAW_W-1:0]   coord_min;
        logic [GAIN_W-1:0]  x_gain;
        logic [GAIN_W-1:0]  y_gain;
        logic [LIMIT_W-1:0] x_limit;
        logic [LIMIT_W-1:0] y_limit;
    } trds_cfg_t;

endpackage

FILE: rtl/core/trds_front.sv
`include "touch_report_decoder_scaler_macros.svh"

module trds_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [trds_pkg::BYTE_W-1:0]   rx_byte,
    input  logic [trds_pkg::BYTE_W-1:0]   press_code,
    input  logic                          q_full,
    output logic                          push,
    output trds_pkg::trds_raw_t           push_data
);
    import trds_pkg::*;

    trds_pos_t         pos_reg;
    trds_pos_t         pos_next;
    logic [BYTE_W-1:0] x_low_reg;
    logic [BYTE_W-1:0] x_high_reg;
    logic [BYTE_W-1:0] y_low_reg;
    logic              accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HUNT;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && pos_reg == POS_X_LOW)
        begin
            x_low_reg <= rx_byte;
        end
        if (accept && pos_reg == POS_X_HIGH)
        begin
            x_high_reg <= rx_byte;
        end
        if (accept && pos_reg == POS_Y_LOW)
        begin
            y_low_reg <= rx_byte;
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        push     = 1'b0;
        if (accept)
        begin
            unique case (pos_reg)
                POS_HUNT:   pos_next = (rx_byte == press_code) ? POS_X_LOW : POS_HUNT;
                POS_X_LOW:  pos_next = POS_X_HIGH;
                POS_X_HIGH: pos_next = POS_Y_LOW;
                POS_Y_LOW:  pos_next = POS_Y_HIGH;
                POS_Y_HIGH:
                begin
                    pos_next = POS_HUNT;
                    push     = 1'b1;
                end
                default:    pos_next = POS_HUNT;
            endcase
        end
    end

    assign push_data.raw_x = (RAW_W'(x_high_reg) << HIGH_SHIFT) + RAW_W'(x_low_reg);
    assign push_data.raw_y = (RAW_W'(rx_byte) << HIGH_SHIFT) + RAW_W'(y_low_reg);

    `TRDS_ASSERT_NEXT(a_frame_ends_in_hunt, clk, rst_n, accept && pos_reg == POS_Y_HIGH, pos_reg == POS_HUNT)

endmodule

FILE: rtl/core/trds_queue.sv
`include "touch_report_decoder_scaler_macros.svh"

module trds_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  trds_pkg::trds_raw_t push_data,
    output logic                full,
    output logic                q_valid,
    input  logic                pop,
    output trds_pkg::trds_raw_t q_data
);
    import trds_pkg::*;

    trds_raw_t           entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_CW-1:0] count_next;

    assign full    = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    `TRDS_ASSERT_IMP(a_no_push_when_full, clk, rst_n, push, !full)
    `TRDS_ASSERT_IMP(a_no_pop_when_empty, clk, rst_n, pop, q_valid)
    `TRDS_ASSERT_IMP(a_count_in_range, clk, rst_n, 1'b1, count_reg <= QUEUE_CW'(QUEUE_DEPTH))

endmodule

FILE: rtl/core/trds_back.sv
`include "touch_report_decoder_scaler_macros.svh"

module trds_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  trds_pkg::trds_cfg_t            cfg,
    input  logic                           q_valid,
    input  trds_pkg::trds_raw_t            q_data,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [trds_pkg::LIMIT_W-1:0]   pixel_x,
    output logic [trds_pkg::LIMIT_W-1:0]   pixel_y,
    output logic [trds_pkg::RAW_W-1:0]     raw_x,
    output logic [trds_pkg::RAW_W-1:0]     raw_y,
    output logic                           clipped
);
    import trds_pkg::*;

    logic                a_valid_reg;
    trds_raw_t           a_raw_reg;
    logic [RAW_W-1:0]    a_dx_reg;
    logic [RAW_W-1:0]    a_dy_reg;
    logic                a_low_reg;

    logic                b_valid_reg;
    trds_raw_t           b_raw_reg;
    logic [PROD_W-1:0]   b_px_reg;
    logic [PROD_W-1:0]   b_py_reg;
    logic                b_low_reg;

    logic                out_valid_reg;
    logic [LIMIT_W-1:0]  pixel_x_reg;
    logic [LIMIT_W-1:0]  pixel_y_reg;
    logic [RAW_W-1:0]    raw_x_reg;
    logic [RAW_W-1:0]    raw_y_reg;
    logic                clipped_reg;

    logic                en_a;
    logic                en_b;
    logic                en_c;
    logic                low_x;
    logic                low_y;
    logic [LIMIT_W-1:0]  lim_x;
    logic [LIMIT_W-1:0]  lim_y;
    logic [SCALED_W-1:0] scaled_x;
    logic [SCALED_W-1:0] scaled_y;
    logic                over_x;
    logic                over_y;

    assign en_c = !out_valid_reg || !out_stall;
    assign en_b = !b_valid_reg || en_c;
    assign en_a = !a_valid_reg || en_b;
    assign pop  = en_a && q_valid;

    assign low_x = q_data.raw_x < cfg.coord_min;
    assign low_y = q_data.raw_y < cfg.coord_min;

    assign lim_x    = (cfg.x_limit < PIX_MAX) ? cfg.x_limit : PIX_MAX;
    assign lim_y    = (cfg.y_limit < PIX_MAX) ? cfg.y_limit : PIX_MAX;
    assign scaled_x = b_px_reg[PROD_W-1:GAIN_FRAC];
    assign scaled_y = b_py_reg[PROD_W-1:GAIN_FRAC];
    assign over_x   = scaled_x > SCALED_W'(lim_x);
    assign over_y   = scaled_y > SCALED_W'(lim_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                a_valid_reg <= q_valid;
            end
            if (en_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (en_c)
            begin
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_raw_reg <= q_data;
            a_dx_reg  <= low_x ? '0 : q_data.raw_x - cfg.coord_min;
            a_dy_reg  <= low_y ? '0 : q_data.raw_y - cfg.coord_min;
            a_low_reg <= low_x || low_y;
        end
        if (en_b)
        begin
            b_raw_reg <= a_raw_reg;
            b_px_reg  <= PROD_W'(a_dx_reg) * PROD_W'(cfg.x_gain);
            b_py_reg  <= PROD_W'(a_dy_reg) * PROD_W'(cfg.y_gain);
            b_low_reg <= a_low_reg;
        end
        if (en_c)
        begin
            raw_x_reg   <= b_raw_reg.raw_x;
            raw_y_reg   <= b_raw_reg.raw_y;
            pixel_x_reg <= over_x ? lim_x : scaled_x[LIMIT_W-1:0];
            pixel_y_reg <= over_y ? lim_y : scaled_y[LIMIT_W-1:0];
            clipped_reg <= b_low_reg || over_x || over_y;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_x   = pixel_x_reg;
    assign pixel_y   = pixel_y_reg;
    assign raw_x     = raw_x_reg;
    assign raw_y     = raw_y_reg;
    assign clipped   = clipped_reg;

    `TRDS_ASSERT_IMP(a_pixel_x_within_limit, clk, rst_n, out_valid_reg, pixel_x_reg <= cfg.x_limit)
    `TRDS_ASSERT_IMP(a_pixel_y_within_limit, clk, rst_n, out_valid_reg, pixel_y_reg <= cfg.y_limit)

endmodule

FILE: rtl/core/touch_report_decoder_scaler.sv
// A frame waits in the queue, then passes through stage a and stage b to the output register.
// Throughput: one byte and one scaled frame per cycle, unless a stall holds them back.
// The two-entry frame queue sets the only input stall, raised while it is full.
// Reset is asynchronous and active low; it returns the parser to hunting, empties the
// queue and pipeline, and loads the register reset values.
module touch_report_decoder_scaler (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [trds_pkg::BYTE_W-1:0]        rx_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [trds_pkg::LIMIT_W-1:0]       pixel_x,
    output logic [trds_pkg::LIMIT_W-1:0]       pixel_y,
    output logic [trds_pkg::RAW_W-1:0]         raw_x,
    output logic [trds_pkg::RAW_W-1:0]         raw_y,
    output logic                               clipped,
    input  logic                               cfg_we,
    input  logic [trds_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [trds_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import trds_pkg::*;

    logic [BYTE_W-1:0] press_code_reg;
    trds_cfg_t         cfg_reg;
    logic              q_full;
    logic              push;
    trds_raw_t         push_data;
    logic              q_valid;
    logic              pop;
    trds_raw_t         q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_code_reg    <= BYTE_W'(129);
            cfg_reg.coord_min <= '0;
            cfg_reg.x_gain    <= GAIN_W'(12803);
            cfg_reg.y_gain    <= GAIN_W'(7682);
            cfg_reg.x_limit   <= LIMIT_W'(799);
            cfg_reg.y_limit   <= LIMIT_W'(479);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PRESS_CODE: press_code_reg    <= cfg_data[BYTE_W-1:0];
                REG_COORD_MIN:  cfg_reg.coord_min <= cfg_data[RAW_W-1:0];
                REG_X_GAIN:     cfg_reg.x_gain    <= cfg_data[GAIN_W-1:0];
                REG_Y_GAIN:     cfg_reg.y_gain    <= cfg_data[GAIN_W-1:0];
                REG_X_LIMIT:    cfg_reg.x_limit   <= cfg_data[LIMIT_W-1:0];
                REG_Y_LIMIT:    cfg_reg.y_limit   <= cfg_data[LIMIT_W-1:0];
                default:        press_code_reg    <= press_code_reg;
            endcase
        end
    end

    trds_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .press_code (press_code_reg),
        .q_full     (q_full),
        .push       (push),
        .push_data  (push_data)
    );

    trds_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .q_valid    (q_valid),
        .pop        (pop),
        .q_data     (q_data)
    );

    trds_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .raw_x      (raw_x),
        .raw_y      (raw_y),
        .clipped    (clipped)
    );

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
    import trds_pkg::*;

    localparam int DRAIN_PAUSE      = 8;
    localparam int DRAIN_LIMIT      = 50000;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int RANDOM_PHASES    = 6;
    localparam int PHASE_BYTES      = 330;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [BYTE_W-1:0]  RST_PRESS_CODE = 8'd129;
    localparam logic [RAW_W-1:0]   RST_COORD_MIN  = 16'd0;
    localparam logic [GAIN_W-1:0]  RST_X_GAIN     = 24'd12803;
    localparam logic [GAIN_W-1:0]  RST_Y_GAIN     = 24'd7682;
    localparam logic [LIMIT_W-1:0] RST_X_LIMIT    = 12'd799;
    localparam logic [LIMIT_W-1:0] RST_Y_LIMIT    = 12'd479;
    localparam logic [GAIN_W-1:0]  GAIN_ONE       = 24'h010000;
    localparam logic [RAW_W-1:0]   RAW_TOP        = 16'd32895;

    typedef struct packed {
        logic [LIMIT_W-1:0] pixel_x;
        logic [LIMIT_W-1:0] pixel_y;
        logic [RAW_W-1:0]   raw_x;
        logic [RAW_W-1:0]   raw_y;
        logic               clipped;
    } touch_point_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [BYTE_W-1:0]      rx_byte = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [LIMIT_W-1:0]     pixel_x;
    logic [LIMIT_W-1:0]     pixel_y;
    logic [RAW_W-1:0]       raw_x;
    logic [RAW_W-1:0]       raw_y;
    logic                   clipped;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    touch_point_t pending_points[$];
    touch_point_t arrived_point;

    trds_pos_t         frame_pos;
    logic [BYTE_W-1:0] x_lo_byte;
    logic [BYTE_W-1:0] x_hi_byte;
    logic [BYTE_W-1:0] y_lo_byte;
    logic [BYTE_W-1:0] press_code_m;
    trds_cfg_t         scale_cfg;

    int  errors = 0;
    int  results_checked = 0;
    int  clipped_seen = 0;
    int  bytes_sent = 0;
    int  settings_loaded = 0;
    int  stall_hits = 0;
    bit  gaps_on = 1'b1;
    bit  stalls_on = 1'b1;
    bit  hold_off_req = 1'b0;

    touch_report_decoder_scaler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .raw_x     (raw_x),
        .raw_y     (raw_y),
        .clipped   (clipped),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [LIMIT_W-1:0] scale_coord(input logic [RAW_W-1:0] raw,
                                                       input logic [GAIN_W-1:0] gain,
                                                       input logic [LIMIT_W-1:0] limit,
                                                       output logic clip);
        logic [LIMIT_W-1:0]  ceiling;
        logic [PROD_W-1:0]   product;
        logic [SCALED_W-1:0] scaled;
        ceiling = (limit < PIX_MAX) ? limit : PIX_MAX;
        clip = 1'b0;
        if (raw < scale_cfg.coord_min)
        begin
            clip = 1'b1;
            return '0;
        end
        product = PROD_W'(raw - scale_cfg.coord_min) * PROD_W'(gain);
        scaled = SCALED_W'(product >> GAIN_FRAC);
        if (scaled > SCALED_W'(ceiling))
        begin
            clip = 1'b1;
            return ceiling;
        end
        return scaled[LIMIT_W-1:0];
    endfunction

    task automatic reset_decoder_state();
        frame_pos = POS_HUNT;
        x_lo_byte = '0;
        x_hi_byte = '0;
        y_lo_byte = '0;
        press_code_m = RST_PRESS_CODE;
        scale_cfg.coord_min = RST_COORD_MIN;
        scale_cfg.x_gain = RST_X_GAIN;
        scale_cfg.y_gain = RST_Y_GAIN;
        scale_cfg.x_limit = RST_X_LIMIT;
        scale_cfg.y_limit = RST_Y_LIMIT;
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        touch_point_t pt;
        logic clip_x;
        logic clip_y;
        case (frame_pos)
            POS_X_LOW:
            begin
                x_lo_byte = b;
                frame_pos = POS_X_HIGH;
            end
            POS_X_HIGH:
            begin
                x_hi_byte = b;
                frame_pos = POS_Y_LOW;
            end
            POS_Y_LOW:
            begin
                y_lo_byte = b;
                frame_pos = POS_Y_HIGH;
            end
            POS_Y_HIGH:
            begin
                pt.raw_x = (RAW_W'(x_hi_byte) << HIGH_SHIFT) + RAW_W'(x_lo_byte);
                pt.raw_y = (RAW_W'(b) << HIGH_SHIFT) + RAW_W'(y_lo_byte);
                pt.pixel_x = scale_coord(pt.raw_x, scale_cfg.x_gain, scale_cfg.x_limit, clip_x);
                pt.pixel_y = scale_coord(pt.raw_y, scale_cfg.y_gain, scale_cfg.y_limit, clip_y);
                pt.clipped = clip_x | clip_y;
                pending_points.push_back(pt);
                frame_pos = POS_HUNT;
            end
            default:
            begin
                frame_pos = (b == press_code_m) ? POS_X_LOW : POS_HUNT;
            end
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        decode_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] code, input logic [BYTE_W-1:0] xl,
                              input logic [BYTE_W-1:0] xh, input logic [BYTE_W-1:0] yl,
                              input logic [BYTE_W-1:0] yh);
        send_byte(code);
        send_byte(xl);
        send_byte(xh);
        send_byte(yl);
        send_byte(yh);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_PRESS_CODE: press_code_m = data[BYTE_W-1:0];
            REG_COORD_MIN:  scale_cfg.coord_min = data[RAW_W-1:0];
            REG_X_GAIN:     scale_cfg.x_gain = data[GAIN_W-1:0];
            REG_Y_GAIN:     scale_cfg.y_gain = data[GAIN_W-1:0];
            REG_X_LIMIT:    scale_cfg.x_limit = data[LIMIT_W-1:0];
            REG_Y_LIMIT:    scale_cfg.y_limit = data[LIMIT_W-1:0];
            default:        ;
        endcase
    endtask

    // Unused upper data bits carry random values so that register masking is covered.
    task automatic load_settings(input logic [BYTE_W-1:0] code, input logic [RAW_W-1:0] lowest,
                                 input logic [GAIN_W-1:0] gx, input logic [GAIN_W-1:0] gy,
                                 input logic [LIMIT_W-1:0] lx, input logic [LIMIT_W-1:0] ly);
        wait_drain();
        set_reg(REG_PRESS_CODE, {16'($urandom), code});
        set_reg(REG_COORD_MIN, {8'($urandom), lowest});
        set_reg(REG_X_GAIN, gx);
        set_reg(REG_Y_GAIN, gy);
        set_reg(REG_X_LIMIT, {12'($urandom), lx});
        set_reg(REG_Y_LIMIT, {12'($urandom), ly});
        set_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 24'($urandom));
        settings_loaded++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_data_byte();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return press_code_m;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_ONE;
            3:       return 24'($urandom);
            default: return 24'($urandom_range(0, 24'h3000));
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] pick_coord_min();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return RAW_TOP;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, 3000));
        endcase
    endfunction

    task automatic run_random_bytes(input int n_bytes);
        int sent;
        int kind;
        int partial;
        sent = 0;
        while (sent < n_bytes)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 82)
            begin
                send_frame(press_code_m, pick_data_byte(), pick_data_byte(),
                           pick_data_byte(), pick_data_byte());
                sent += 5;
            end
            else if (kind < 92)
            begin
                send_byte(8'($urandom));
            end
            else
            begin
                partial = $urandom_range(1, 3);
                send_byte(press_code_m);
                repeat (partial) send_byte(pick_data_byte());
                sent += partial + 1;
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_stall)
            stall_hits++;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_points.size() == 0)
            begin
                $error("result transaction with no expected touch report");
                errors++;
            end
            else
            begin
                arrived_point = pending_points.pop_front();
                check_field("pixel_x", arrived_point.pixel_x, pixel_x);
                check_field("pixel_y", arrived_point.pixel_y, pixel_y);
                check_field("raw_x", arrived_point.raw_x, raw_x);
                check_field("raw_y", arrived_point.raw_y, raw_y);
                check_field("clipped", arrived_point.clipped, clipped);
                results_checked++;
                if (arrived_point.clipped)
                    clipped_seen++;
            end
        end
    end

    initial
    begin : receiver
        int r;
        int span;
        int hold_cycles;
        logic level;
        forever
        begin
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                for (hold_cycles = 0; hold_cycles < HOLD_OFF_CYCLES; hold_cycles++)
                    @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (!stalls_on || r < 55)
                begin
                    level = 1'b0;
                    span = stalls_on ? $urandom_range(1, 12) : 1;
                end
                else
                begin
                    level = 1'b1;
                    span = (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
                end
                out_stall <= level;
                repeat (span) @(posedge clk);
            end
        end
    end

    task automatic test_default_frames();
        send_byte(8'h00);
        send_frame(press_code_m, 8'h00, 8'h00, 8'h00, 8'h00);
        send_frame(press_code_m, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_frame(press_code_m, press_code_m, 8'h01, press_code_m, 8'h02);
    endtask

    // Unity gain makes raw minus minimum land exactly on the limit, one above it, and below zero.
    task automatic test_clamping();
        load_settings(RST_PRESS_CODE, 16'd100, GAIN_ONE, GAIN_ONE, 12'd50, 12'd4095);
        send_frame(press_code_m, 8'd22, 8'd1, 8'd100, 8'd0);
        send_frame(press_code_m, 8'd23, 8'd1, 8'd99, 8'd0);
    endtask

    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_off_req = 1'b1;
        repeat (20)
            send_frame(press_code_m, pick_data_byte(), pick_data_byte(),
                       pick_data_byte(), pick_data_byte());
        gaps_on = 1'b1;
        wait_drain();
    endtask

    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                load_settings('0, '0, '0, '0, '0, '0);
            else if (phase == 1)
                load_settings('1, RAW_TOP, '1, '1, '1, '1);
            else
                load_settings(8'($urandom), pick_coord_min(), pick_gain(), pick_gain(),
                              pick_limit(), pick_limit());
            gaps_on = (phase != 2);
            stalls_on = (phase != 2);
            run_random_bytes(PHASE_BYTES);
        end
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial
    begin : stimulus
        int drain_cycles;
        reset_decoder_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_frames();
        test_clamping();
        test_backpressure();
        test_random_traffic();
        in_valid <= 1'b0;
        drain_cycles = 0;
        while (pending_points.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (DRAIN_PAUSE) @(posedge clk);
        if (pending_points.size() != 0)
        begin
            $error("%0d expected touch reports never arrived", pending_points.size());
            errors++;
        end
        $display("Checked %0d touch reports (%0d clipped) from %0d bytes under %0d settings.",
                 results_checked, clipped_seen, bytes_sent, settings_loaded + 1);
        $display("The input was held off for %0d cycles while results backed up.", stall_hits);
        if (errors == 0)
            $display("** touch_report_decoder_scaler: PASSED **");
        else
            $display("** touch_report_decoder_scaler: FAILED **");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("** touch_report_decoder_scaler: FAILED **");
        $finish;
    end

endmodule
